### sv/caf_pkg.sv
// Shared types, constants and the arctangent table of the complementary attitude filter.
package caf_pkg;

    localparam int IN_W  = 144;
    localparam int OUT_W = 200;

    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [24:0] GAIN_ONE = 25'h100_0000;
    // ceil(2^24 / 3): exact floor division by three for operands below 2^23
    localparam logic [22:0] RECIP3   = 23'd5592406;
    localparam logic [15:0] CUTOFF_RST = 16'd5120;
    localparam logic [16:0] BLEND_RST  = 17'd64225;
    localparam logic [16:0] BLEND_ONE  = 17'd65536;
    localparam logic signed [19:0] ACCEL_Z_RST = -20'sd40182;
    localparam logic [4:0] SQ_LAST    = 5'd7;
    localparam logic [4:0] ROOT_LAST  = 5'd27;
    localparam logic [4:0] CORDIC_LAST = 5'd16;
    localparam logic [1:0] AXIS_LAST  = 2'd2;
    localparam logic [1:0] PASS_LAST  = 2'd1;
    localparam logic CFG_CUTOFF = 1'b0;
    localparam logic CFG_BLEND  = 1'b1;

    typedef enum logic [5:0] {
        OP_NONE, OP_CX, OP_Y, OP_Y2, OP_Y2S, OP_Y3, OP_Y3S, OP_Y4, OP_Y4S,
        OP_D6, OP_D6S, OP_D24, OP_E, OP_SQ, OP_SQS, OP_G, OP_FM, OP_FS,
        OP_P2, OP_P2S, OP_Q2, OP_Q2S, OP_RT, OP_CL, OP_CI, OP_CS,
        OP_RD, OP_GY, OP_BA, OP_BB, OP_BC, OP_YD, OP_YS
    } t_op;

    typedef enum logic [5:0] {
        ST_IDLE, ST_CHECK, ST_CX, ST_Y, ST_Y2, ST_Y2S, ST_Y3, ST_Y3S, ST_Y4,
        ST_Y4S, ST_D6, ST_D6S, ST_D24, ST_E, ST_SQ, ST_SQS, ST_G, ST_FM, ST_FS,
        ST_P2, ST_P2S, ST_Q2, ST_Q2S, ST_RT, ST_CL, ST_CI, ST_CS,
        ST_RD, ST_GY, ST_BA, ST_BB, ST_BC, ST_YD, ST_YS, ST_DONE
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [4:0] step;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic dt_zero;
    } t_status;

    function automatic logic signed [18:0] f_atan(input logic [4:0] i);
        logic signed [18:0] v;
        case (i)
            5'd0:  v = 19'sd51472;
            5'd1:  v = 19'sd30386;
            5'd2:  v = 19'sd16055;
            5'd3:  v = 19'sd8150;
            5'd4:  v = 19'sd4091;
            5'd5:  v = 19'sd2047;
            5'd6:  v = 19'sd1024;
            5'd7:  v = 19'sd512;
            5'd8:  v = 19'sd256;
            5'd9:  v = 19'sd128;
            5'd10: v = 19'sd64;
            5'd11: v = 19'sd32;
            5'd12: v = 19'sd16;
            5'd13: v = 19'sd8;
            5'd14: v = 19'sd4;
            5'd15: v = 19'sd2;
            5'd16: v = 19'sd1;
            default: v = 19'sd0;
        endcase
        return v;
    endfunction

endpackage

### sv/complementary_attitude_filter.sv
// Top level of the complementary roll/pitch/yaw attitude filter.
//
//  Channel   Direction  Ports                            Contents
//  s         in         i_s_tvalid/o_s_tready/i_s_tdata  one IMU sample
//  m         out        o_m_tvalid/i_m_tready/o_m_tdata  angles, rates, filtered accel
//  cfg       in         i_cfg_wr_en/addr/wr_data         0: cutoff, 1: blend gain
//
// Each item with a nonzero time step runs from acceptance to a loaded result through
// the bit-serial square root and the 17 CORDIC rotations, each run once for roll and
// once for pitch, plus eight squarings of the exponential on the shared multiplier.
// An item with a zero time step is dropped in the check state after acceptance and
// leaves the state untouched; the block then returns to idle for the next item.
// Reset is synchronous and restores the registers and the filter state. The block
// takes a new item while the previous result waits in the output register; a
// finished item stalls only if that register is still full.
module complementary_attitude_filter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // time_step, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, 4 zero bits
    input  logic [143:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // roll_angle, pitch_angle, yaw_angle, out_rate_x, out_rate_y, out_rate_z,
    // filtered_x, filtered_y, filtered_z
    output logic [199:0] o_m_tdata,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_addr,
    input  logic [16:0]  i_cfg_wr_data
);
    import caf_pkg::*;

    t_cmd               w_cmd;
    t_status            w_status;
    logic               w_ready, w_load, w_accept, w_out_free;
    logic [OUT_W-1:0]   w_result;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    assign w_accept   = i_s_tvalid && w_ready;
    // The output register can take a new result when empty or being drained.
    assign w_out_free = !r_out_valid || i_m_tready;

    caf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_ready    (w_ready),
        .o_load     (w_load),
        .o_cmd      (w_cmd)
    );

    caf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_capture     (w_accept),
        .i_in_data     (i_s_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_result      (w_result)
    );

    // Output holding register keeps a finished item apart from the working state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_out_data <= w_result;
    end

    assign o_s_tready = w_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

### sv/caf_ctrl.sv
// Sequencer that steps the filter datapath through one sample.
module caf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_out_free,
    input  caf_pkg::t_status i_status,
    output logic             o_ready,
    output logic             o_load,
    output caf_pkg::t_cmd    o_cmd
);
    import caf_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_sel      = r_sel;
        o_ready    = 1'b0;
        o_load     = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.step = r_cnt;
        o_cmd.sel  = r_sel;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_status.dt_zero ? ST_IDLE : ST_CX;
            end
            ST_CX:  begin o_cmd.op = OP_CX;  n_state = ST_Y;   end
            ST_Y:   begin o_cmd.op = OP_Y;   n_state = ST_Y2;  end
            ST_Y2:  begin o_cmd.op = OP_Y2;  n_state = ST_Y2S; end
            ST_Y2S: begin o_cmd.op = OP_Y2S; n_state = ST_Y3;  end
            ST_Y3:  begin o_cmd.op = OP_Y3;  n_state = ST_Y3S; end
            ST_Y3S: begin o_cmd.op = OP_Y3S; n_state = ST_Y4;  end
            ST_Y4:  begin o_cmd.op = OP_Y4;  n_state = ST_Y4S; end
            ST_Y4S: begin o_cmd.op = OP_Y4S; n_state = ST_D6;  end
            ST_D6:  begin o_cmd.op = OP_D6;  n_state = ST_D6S; end
            ST_D6S: begin o_cmd.op = OP_D6S; n_state = ST_D24; end
            ST_D24: begin o_cmd.op = OP_D24; n_state = ST_E;   end
            ST_E: begin
                o_cmd.op = OP_E;
                n_cnt    = '0;
                n_state  = ST_SQ;
            end
            ST_SQ: begin o_cmd.op = OP_SQ; n_state = ST_SQS; end
            ST_SQS: begin
                o_cmd.op = OP_SQS;
                if (r_cnt == SQ_LAST) begin
                    n_state = ST_G;
                end else begin
                    n_cnt   = r_cnt + 5'd1;
                    n_state = ST_SQ;
                end
            end
            ST_G: begin
                o_cmd.op = OP_G;
                n_sel    = '0;
                n_state  = ST_FM;
            end
            ST_FM: begin o_cmd.op = OP_FM; n_state = ST_FS; end
            ST_FS: begin
                o_cmd.op = OP_FS;
                if (r_sel == AXIS_LAST) begin
                    n_sel   = '0;
                    n_state = ST_P2;
                end else begin
                    n_sel   = r_sel + 2'd1;
                    n_state = ST_FM;
                end
            end
            ST_P2:  begin o_cmd.op = OP_P2;  n_state = ST_P2S; end
            ST_P2S: begin o_cmd.op = OP_P2S; n_state = ST_Q2;  end
            ST_Q2:  begin o_cmd.op = OP_Q2;  n_state = ST_Q2S; end
            ST_Q2S: begin
                o_cmd.op = OP_Q2S;
                n_cnt    = '0;
                n_state  = ST_RT;
            end
            ST_RT: begin
                o_cmd.op = OP_RT;
                if (r_cnt == ROOT_LAST) begin
                    n_state = ST_CL;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_CL: begin
                o_cmd.op = OP_CL;
                n_cnt    = '0;
                n_state  = ST_CI;
            end
            ST_CI: begin
                o_cmd.op = OP_CI;
                if (r_cnt == CORDIC_LAST) begin
                    n_state = ST_CS;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_CS: begin
                o_cmd.op = OP_CS;
                if (r_sel == PASS_LAST) begin
                    n_sel   = '0;
                    n_state = ST_RD;
                end else begin
                    n_sel   = r_sel + 2'd1;
                    n_state = ST_P2;
                end
            end
            ST_RD: begin o_cmd.op = OP_RD; n_state = ST_GY; end
            ST_GY: begin o_cmd.op = OP_GY; n_state = ST_BA; end
            ST_BA: begin o_cmd.op = OP_BA; n_state = ST_BB; end
            ST_BB: begin o_cmd.op = OP_BB; n_state = ST_BC; end
            ST_BC: begin
                o_cmd.op = OP_BC;
                if (r_sel == PASS_LAST) begin
                    n_sel   = '0;
                    n_state = ST_YD;
                end else begin
                    n_sel   = r_sel + 2'd1;
                    n_state = ST_RD;
                end
            end
            ST_YD: begin o_cmd.op = OP_YD; n_state = ST_YS;   end
            ST_YS: begin o_cmd.op = OP_YS; n_state = ST_DONE; end
            ST_DONE: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |-> i_out_free) else $error("result loaded into a busy output register");
    a_sq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQS) |-> (r_cnt <= SQ_LAST)) else $error("squaring count overrun");
    a_cordic_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CI) |-> (r_cnt <= CORDIC_LAST)) else $error("rotation count overrun");
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel != 2'd3) else $error("axis select out of range");
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |=> (r_state == ST_CHECK)) else $error("accepted item lost");

endmodule

### sv/caf_dp.sv
// Datapath: shared multiplier, square-root and CORDIC registers, filter state.
module caf_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_capture,
    input  logic [caf_pkg::IN_W-1:0]   i_in_data,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_addr,
    input  logic [16:0]                i_cfg_wr_data,
    input  caf_pkg::t_cmd              i_cmd,
    output caf_pkg::t_status           o_status,
    output logic [caf_pkg::OUT_W-1:0]  o_result
);
    import caf_pkg::*;

    function automatic logic signed [65:0] f_rnd(input logic signed [65:0] v,
                                                 input logic [4:0] k);
        logic signed [65:0] half;
        half = 66'sd1 <<< (k - 5'd1);
        if (v >= 0) return (v + half) >>> k;
        return -((-v + half) >>> k);
    endfunction

    logic [15:0]        r_cutoff;
    logic [16:0]        r_blend;
    logic [19:0]        r_dt;
    logic signed [19:0] r_ax, r_ay, r_az, r_rx, r_ry, r_rz;
    logic signed [19:0] r_sx, r_sy, r_sz;
    logic signed [23:0] r_roll, r_pitch;
    logic [31:0]        r_yaw;

    logic signed [65:0] r_prod, r_bsum;
    logic               r_big;
    logic [26:0]        r_y;
    logic [23:0]        r_y2;
    logic [20:0]        r_y3;
    logic [17:0]        r_y4;
    logic [18:0]        r_q6;
    logic [30:0]        r_e;
    logic [24:0]        r_g;
    logic [39:0]        r_sum;
    logic [55:0]        r_rad;
    logic [31:0]        r_rem;
    logic [27:0]        r_root;
    logic signed [30:0] r_cx, r_cy;
    logic signed [18:0] r_cz;
    logic               r_czero;
    logic signed [18:0] r_roll_acc, r_pitch_acc;
    logic signed [25:0] r_gyro;

    logic [16:0]        w_a;
    logic signed [19:0] w_in_acc, w_s, w_n, w_p, w_rate;
    logic signed [23:0] w_est;
    logic signed [18:0] w_acc;
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    logic               w_mul_en;
    logic signed [20:0] w_diff;
    logic [31:0]        w_e_calc;
    logic [61:0]        w_sq;
    logic [31:0]        w_e_sq;
    logic [30:0]        w_g_raw;
    logic [24:0]        w_g;
    logic signed [65:0] w_fstep, w_dstep, w_blend;
    logic signed [23:0] w_sat;
    logic [31:0]        w_rem_sh, w_trial;
    logic               w_ge;
    logic signed [30:0] w_xs, w_ys;
    logic signed [18:0] w_angle;

    always_comb begin
        w_a = (r_blend > BLEND_ONE) ? BLEND_ONE : r_blend;
        case (i_cmd.sel)
            2'd0:    begin w_in_acc = r_ax; w_s = r_sx; end
            2'd1:    begin w_in_acc = r_ay; w_s = r_sy; end
            default: begin w_in_acc = r_az; w_s = r_sz; end
        endcase
        w_n    = i_cmd.sel[0] ? r_sx : r_sy;
        w_p    = i_cmd.sel[0] ? r_sy : r_sx;
        w_rate = i_cmd.sel[0] ? r_ry : r_rx;
        w_est  = i_cmd.sel[0] ? r_pitch : r_roll;
        w_acc  = i_cmd.sel[0] ? r_pitch_acc : r_roll_acc;
        w_diff = {w_in_acc[19], w_in_acc} - {w_s[19], w_s};
    end

    // One shared multiplier; its operands are chosen by the current operation.
    always_comb begin
        w_ma     = '0;
        w_mb     = '0;
        w_mul_en = 1'b1;
        case (i_cmd.op)
            OP_CX:  begin w_ma = {17'b0, r_cutoff}; w_mb = {13'b0, r_dt}; end
            OP_Y2:  begin w_ma = {6'b0, r_y};  w_mb = {6'b0, r_y}; end
            OP_Y3:  begin w_ma = {9'b0, r_y2}; w_mb = {6'b0, r_y}; end
            OP_Y4:  begin w_ma = {12'b0, r_y3}; w_mb = {6'b0, r_y}; end
            OP_D6:  begin w_ma = {13'b0, r_y3[20:1]}; w_mb = {10'b0, RECIP3}; end
            OP_D24: begin w_ma = {18'b0, r_y4[17:3]}; w_mb = {10'b0, RECIP3}; end
            OP_SQ:  begin w_ma = {2'b0, r_e}; w_mb = {2'b0, r_e}; end
            OP_FM:  begin w_ma = {{12{w_diff[20]}}, w_diff}; w_mb = {8'b0, r_g}; end
            OP_P2:  begin w_ma = {{13{w_p[19]}}, w_p}; w_mb = {{13{w_p[19]}}, w_p}; end
            OP_Q2:  begin w_ma = {{13{r_sz[19]}}, r_sz}; w_mb = {{13{r_sz[19]}}, r_sz}; end
            OP_RD:  begin w_ma = {{13{w_rate[19]}}, w_rate}; w_mb = {13'b0, r_dt}; end
            OP_YD:  begin w_ma = {{13{r_rz[19]}}, r_rz}; w_mb = {13'b0, r_dt}; end
            OP_BA:  begin w_ma = {16'b0, w_a}; w_mb = {{7{r_gyro[25]}}, r_gyro}; end
            OP_BB:  begin
                w_ma = {16'b0, BLEND_ONE - w_a};
                w_mb = {{14{w_acc[18]}}, w_acc};
            end
            default: w_mul_en = 1'b0;
        endcase
        w_prod = w_ma * w_mb;
    end

    always_comb begin
        w_e_calc = {1'b0, ONE_Q30} - {5'b0, r_y} + {9'b0, r_y2[23:1]}
                 - {13'b0, r_q6} + {18'b0, r_prod[37:24]};
        w_sq     = r_prod[61:0] + 62'h2000_0000;
        w_e_sq   = w_sq[61:30];
        w_g_raw  = ONE_Q30 - r_e + 31'd32;
        w_g      = (r_big || (w_g_raw[30:6] > GAIN_ONE)) ? GAIN_ONE : w_g_raw[30:6];
        w_fstep  = f_rnd(r_prod, 5'd24);
        w_dstep  = f_rnd(r_prod, 5'd18);
        w_blend  = f_rnd(r_bsum + r_prod, 5'd16);
        if (w_blend > 66'sd8388607)       w_sat = 24'sh7FFFFF;
        else if (w_blend < -66'sd8388608) w_sat = -24'sh800000;
        else                              w_sat = w_blend[23:0];
        w_rem_sh = {r_rem[29:0], r_rad[55:54]};
        w_trial  = {2'b0, r_root, 2'b01};
        w_ge     = (w_rem_sh >= w_trial);
        w_xs     = r_cx >>> i_cmd.step;
        w_ys     = r_cy >>> i_cmd.step;
        w_angle  = r_czero ? 19'sd0 : r_cz;
    end

    // Configuration and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= CUTOFF_RST;
            r_blend  <= BLEND_RST;
            r_sx     <= '0;
            r_sy     <= '0;
            r_sz     <= ACCEL_Z_RST;
            r_roll   <= '0;
            r_pitch  <= '0;
            r_yaw    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_addr == CFG_CUTOFF) r_cutoff <= i_cfg_wr_data[15:0];
                if (i_cfg_addr == CFG_BLEND)  r_blend  <= i_cfg_wr_data;
            end
            case (i_cmd.op)
                OP_FS: begin
                    case (i_cmd.sel)
                        2'd0:    r_sx <= w_s + w_fstep[19:0];
                        2'd1:    r_sy <= w_s + w_fstep[19:0];
                        default: r_sz <= w_s + w_fstep[19:0];
                    endcase
                end
                OP_BC: begin
                    if (i_cmd.sel[0]) r_pitch <= w_sat;
                    else              r_roll  <= w_sat;
                end
                OP_YS: r_yaw <= r_yaw + w_dstep[31:0];
                default: ;
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_dt <= i_in_data[19:0];
            r_ax <= i_in_data[39:20];
            r_ay <= i_in_data[59:40];
            r_az <= i_in_data[79:60];
            r_rx <= i_in_data[99:80];
            r_ry <= i_in_data[119:100];
            r_rz <= i_in_data[139:120];
        end
        if (w_mul_en) r_prod <= w_prod;
        case (i_cmd.op)
            OP_Y: begin
                r_big <= |r_prod[35:33];
                r_y   <= r_prod[32:6];
            end
            OP_Y2S: r_y2 <= r_prod[53:30];
            OP_Y3S: r_y3 <= r_prod[50:30];
            OP_Y4S: r_y4 <= r_prod[47:30];
            OP_D6S: r_q6 <= r_prod[42:24];
            OP_E:   r_e  <= w_e_calc[30:0];
            OP_SQS: r_e  <= (w_e_sq > {1'b0, ONE_Q30}) ? ONE_Q30 : w_e_sq[30:0];
            OP_G:   r_g  <= w_g;
            OP_P2S: r_sum <= r_prod[39:0];
            OP_Q2S: begin
                r_rad  <= {r_sum + r_prod[39:0], 16'b0};
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_RT: begin
                r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
                r_root <= {r_root[26:0], w_ge};
                r_rad  <= {r_rad[53:0], 2'b00};
            end
            OP_CL: begin
                r_cx    <= {3'b0, r_root};
                r_cy    <= {{3{w_n[19]}}, w_n, 8'b0};
                r_cz    <= '0;
                r_czero <= (r_root == '0) && (w_n == '0);
            end
            OP_CI: begin
                if (!r_cy[30]) begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + f_atan(i_cmd.step);
                end else begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - f_atan(i_cmd.step);
                end
            end
            OP_CS: begin
                if (i_cmd.sel[0]) r_pitch_acc <= w_angle;
                else              r_roll_acc  <= w_angle;
            end
            OP_GY: r_gyro <= {{2{w_est[23]}}, w_est} + w_dstep[25:0];
            OP_BB: r_bsum <= r_prod;
            default: ;
        endcase
    end

    assign o_status.dt_zero = (r_dt == '0);
    assign o_result = {r_sz, r_sy, r_sx, r_rz, r_ry, r_rx, r_yaw, r_pitch, r_roll};

endmodule

### verif/complementary_attitude_filter_tb.sv
// Self-checking testbench for the complementary attitude filter: directed table plus random IMU samples.
module complementary_attitude_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import caf_pkg::*;

    // Codes of the rows of the directed stimulus table.
    typedef enum logic [1:0] {ROW_SAMPLE, ROW_CUTOFF, ROW_BLEND} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [16:0] reg_value;
        logic [19:0] dt;
        logic [19:0] ax;
        logic [19:0] ay;
        logic [19:0] az;
        logic [19:0] rx;
        logic [19:0] ry;
        logic [19:0] rz;
    } t_row;

    localparam logic [19:0] S_MAX = 20'h7FFFF;
    localparam logic [19:0] S_MIN = 20'h80000;
    localparam logic [19:0] DT_MAX = 20'hFFFFF;
    localparam logic [19:0] GRAV_Z = 20'hF6306;   // -40186, gravity at rest
    localparam int N_DIR = 21;
    localparam int PER_PHASE = 362;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    // time_step, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, 4 zero bits
    logic [143:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // roll_angle, pitch_angle, yaw_angle, out_rate_x, out_rate_y, out_rate_z,
    // filtered_x, filtered_y, filtered_z
    logic [199:0] o_m_tdata;
    logic         i_cfg_wr_en = 1'b0;
    logic         i_cfg_addr = CFG_CUTOFF;
    logic [16:0]  i_cfg_wr_data = '0;

    complementary_attitude_filter dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Own copy of the filter state and of the two registers.
    logic [15:0] cutoff_q;
    logic [16:0] blend_q;
    longint      smooth_x, smooth_y, smooth_z, roll_q, pitch_q;
    logic [31:0] yaw_q;

    logic [199:0] pending_results[$];
    int  mismatch_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  skipped_items = 0;
    int  sender_idle_pct = 0;
    int  recv_stall_pct = 0;

    // Field layout of one result, lowest bit first.
    int    fld_off[9] = '{0, 24, 48, 80, 100, 120, 140, 160, 180};
    int    fld_wid[9] = '{24, 24, 32, 20, 20, 20, 20, 20, 20};
    string fld_name[9] = '{"roll_angle", "pitch_angle", "yaw_angle", "out_rate_x",
                           "out_rate_y", "out_rate_z", "filtered_x", "filtered_y",
                           "filtered_z"};

    longint atan_steps[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                               128, 64, 32, 16, 8, 4, 2, 1};

    // Divide by 2^k, rounding half away from zero.
    function automatic longint round_shift(longint v, int k);
        longint half;
        half = longint'(1) <<< (k - 1);
        if (v >= 0) return (v + half) >>> k;
        return -(((-v) + half) >>> k);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // atan2(n, sqrt(p^2 + q^2)) by CORDIC vectoring, result in 2^-16 rad.
    function automatic longint tilt_angle(longint n, longint p, longint q);
        longint unsigned mag2;
        longint x, y, z, nx, ny;
        mag2 = longint'(p * p) + longint'(q * q);
        x = longint'(int_sqrt(mag2 << 16));
        y = n * 256;
        z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < 17; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + atan_steps[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - atan_steps[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    // Low-pass gain 1 - exp(-c*dt) in Q24, with a truncated series and eight squarings.
    function automatic longint smoothing_gain(longint unsigned dt);
        longint unsigned x, y, y2, y3, y4, e, g;
        x = longint'(cutoff_q) * dt;
        if (x >= (64'd32 << 28)) return 64'd1 << 24;
        y = x >> 6;
        y2 = (y * y) >> 30;
        y3 = (y2 * y) >> 30;
        y4 = (y3 * y) >> 30;
        e = (64'd1 << 30) - y + y2 / 2 - y3 / 6 + y4 / 24;
        for (int i = 0; i < 8; i++) e = (e * e + (64'd1 << 29)) >> 30;
        if (e > (64'd1 << 30)) e = 64'd1 << 30;
        g = ((64'd1 << 30) - e + 32) >> 6;
        if (g > (64'd1 << 24)) g = 64'd1 << 24;
        return longint'(g);
    endfunction

    function automatic longint blend_angle(longint est, longint rate, longint dt,
                                           longint acc, longint a);
        longint v;
        v = round_shift(a * (est + round_shift(rate * dt, 18)) + (65536 - a) * acc, 16);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v;
    endfunction

    // Advances the attitude state by one sample; returns 0 when the sample is skipped.
    function automatic bit attitude_update(input logic [143:0] d, output logic [199:0] r);
        longint dt, ax, ay, az, rx, ry, rz, g, a, roll_acc, pitch_acc;
        dt = longint'(d[19:0]);
        ax = longint'($signed(d[39:20]));
        ay = longint'($signed(d[59:40]));
        az = longint'($signed(d[79:60]));
        rx = longint'($signed(d[99:80]));
        ry = longint'($signed(d[119:100]));
        rz = longint'($signed(d[139:120]));
        r = '0;
        if (dt == 0) return 1'b0;
        g = smoothing_gain(longint'(dt));
        smooth_x = smooth_x + round_shift((ax - smooth_x) * g, 24);
        smooth_y = smooth_y + round_shift((ay - smooth_y) * g, 24);
        smooth_z = smooth_z + round_shift((az - smooth_z) * g, 24);
        roll_acc = tilt_angle(smooth_y, smooth_x, smooth_z);
        pitch_acc = tilt_angle(smooth_x, smooth_y, smooth_z);
        // A gain register above one acts as exactly one.
        a = (blend_q > BLEND_ONE) ? 65536 : longint'(blend_q);
        roll_q = blend_angle(roll_q, rx, dt, roll_acc, a);
        pitch_q = blend_angle(pitch_q, ry, dt, pitch_acc, a);
        yaw_q = yaw_q + 32'(round_shift(rz * dt, 18));
        r = {smooth_z[19:0], smooth_y[19:0], smooth_x[19:0], d[139:80], yaw_q,
             pitch_q[23:0], roll_q[23:0]};
        return 1'b1;
    endfunction

    // Sender: idles at random, then holds the item until the block takes it.
    task automatic send_item(input logic [143:0] d);
        logic [199:0] r;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= d;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        if (attitude_update(d, r)) pending_results.push_back(r);
        else skipped_items++;
    endtask

    // Registers are only written with the block idle; a skipped item may still be in flight.
    task automatic write_reg(input logic addr, input logic [16:0] value);
        @(posedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (addr == CFG_CUTOFF) cutoff_q = value[15:0];
        else blend_q = value;
    endtask

    // Mostly a steady IMU at rest with noise; a large share spins the yaw at full rate
    // so that the integrated yaw wraps, the rest is full-range noise and skipped samples.
    function automatic logic [143:0] random_sample();
        logic [19:0] dt, ax, ay, az, rx, ry, rz;
        int pick;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 20) begin
            ax = 20'($urandom); ay = 20'($urandom); az = 20'($urandom);
        end else begin
            ax = 20'($signed($urandom_range(16000)) - 8000);
            ay = 20'($signed($urandom_range(16000)) - 8000);
            az = GRAV_Z + 20'($signed($urandom_range(8000)) - 4000);
        end
        if ($urandom_range(99) < 30) begin
            rx = 20'($urandom); ry = 20'($urandom);
        end else begin
            rx = 20'($signed($urandom_range(40000)) - 20000);
            ry = 20'($signed($urandom_range(40000)) - 20000);
        end
        if (pick < 72) begin
            dt = DT_MAX;
            rz = S_MAX;
        end else begin
            rz = 20'($urandom);
            if (pick < 78) dt = '0;
            else if (pick < 88) dt = 20'($urandom);
            else dt = 20'($urandom_range(20000, 500));
        end
        return {4'b0, rz, ry, rx, az, ay, ax, dt};
    endfunction

    // Result checker and receiver stall generator.
    always @(posedge i_clk) begin
        logic [199:0] want;
        bit bad;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result %h", o_m_tdata);
            end else begin
                want = pending_results.pop_front();
                bad = 1'b0;
                for (int f = 0; f < 9; f++) begin
                    if (((want ^ o_m_tdata) >> fld_off[f]) & ((200'd1 << fld_wid[f]) - 1)) begin
                        bad = 1'b1;
                        if (mismatch_count < 10)
                            $display("ERROR: result %0d %s expected %h got %h", results_seen,
                                     fld_name[f], (want >> fld_off[f]) & ((200'd1 << fld_wid[f]) - 1),
                                     (o_m_tdata >> fld_off[f]) & ((200'd1 << fld_wid[f]) - 1));
                    end
                end
                if (bad) mismatch_count++;
            end
        end
        i_m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    // Directed part: extremes, saturation, the gain above one, the zero vector,
    // a zero cutoff and a skipped sample.
    t_row dir_rows[N_DIR];

    initial begin
        logic [143:0] d;
        dir_rows = '{
            '{ROW_SAMPLE, 17'd0, 20'd0, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX},
            '{ROW_SAMPLE, 17'd0, 20'd1, 20'd0, 20'd0, GRAV_Z, 20'd0, 20'd0, 20'd0},
            '{ROW_SAMPLE, 17'd0, 20'd4096, 20'd3000, 20'hFF000, GRAV_Z, 20'd100, 20'd5, 20'hFFF00},
            '{ROW_BLEND, BLEND_ONE, '0, '0, '0, '0, '0, '0, '0},
            '{ROW_SAMPLE, 17'd0, DT_MAX, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX},
            '{ROW_SAMPLE, 17'd0, DT_MAX, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX},
            '{ROW_SAMPLE, 17'd0, DT_MAX, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX},
            '{ROW_SAMPLE, 17'd0, DT_MAX, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX},
            '{ROW_SAMPLE, 17'd0, DT_MAX, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX},
            '{ROW_BLEND, 17'h1FFFF, '0, '0, '0, '0, '0, '0, '0},
            '{ROW_SAMPLE, 17'd0, DT_MAX, S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, S_MIN},
            '{ROW_CUTOFF, 17'hFFFF, '0, '0, '0, '0, '0, '0, '0},
            '{ROW_SAMPLE, 17'd0, DT_MAX, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0},
            '{ROW_SAMPLE, 17'd0, DT_MAX, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN},
            '{ROW_CUTOFF, 17'd0, '0, '0, '0, '0, '0, '0, '0},
            '{ROW_SAMPLE, 17'd0, DT_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX},
            '{ROW_CUTOFF, 17'd5120, '0, '0, '0, '0, '0, '0, '0},
            '{ROW_BLEND, 17'd0, '0, '0, '0, '0, '0, '0, '0},
            '{ROW_SAMPLE, 17'd0, 20'd1, S_MAX, S_MAX, S_MAX, 20'd1, 20'hFFFFF, 20'd7},
            '{ROW_SAMPLE, 17'd0, 20'd1000, S_MIN, 20'd12345, 20'd0, 20'd99, 20'd0, 20'd0},
            '{ROW_BLEND, BLEND_RST, '0, '0, '0, '0, '0, '0, '0}
        };
        cutoff_q = CUTOFF_RST;
        blend_q = BLEND_RST;
        smooth_x = 0;
        smooth_y = 0;
        smooth_z = longint'(ACCEL_Z_RST);
        roll_q = 0;
        pitch_q = 0;
        yaw_q = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            case (dir_rows[k].kind)
                ROW_CUTOFF: write_reg(CFG_CUTOFF, dir_rows[k].reg_value);
                ROW_BLEND:  write_reg(CFG_BLEND, dir_rows[k].reg_value);
                default: begin
                    send_item({4'b0, dir_rows[k].rz, dir_rows[k].ry, dir_rows[k].rx,
                               dir_rows[k].az, dir_rows[k].ay, dir_rows[k].ax,
                               dir_rows[k].dt});
                end
            endcase
        end

        // Four phases of random samples, each with its own idling and register setting.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_CUTOFF, 17'(CUTOFF_RST));
                    write_reg(CFG_BLEND, BLEND_RST);
                end
                1: begin
                    write_reg(CFG_CUTOFF, 17'hFFFF);
                    write_reg(CFG_BLEND, 17'd0);
                end
                2: begin
                    write_reg(CFG_CUTOFF, 17'd0);
                    write_reg(CFG_BLEND, BLEND_ONE);
                end
                default: begin
                    write_reg(CFG_CUTOFF, 17'($urandom_range(65535)));
                    write_reg(CFG_BLEND, 17'($urandom_range(131071)));
                end
            endcase
            sender_idle_pct = (ph == 1) ? 87 : (ph == 3) ? 13 : 0;
            recv_stall_pct = (ph == 2) ? 87 : (ph == 3) ? 13 : 0;
            for (int n = 0; n < PER_PHASE; n++) begin
                d = random_sample();
                send_item(d);
            end
        end

        @(posedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Sent %0d samples (%0d skipped) and checked %0d results", items_sent,
                 skipped_items, results_seen);
        $display("over four register settings and all idle and stall patterns; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
